>>> design/mm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants, types and helpers for the murmur3 32-bit byte hash.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 3;

  // mixing constants of the x86_32 variant
  localparam logic [WordW-1:0] C1    = 32'hcc9e2d51;
  localparam logic [WordW-1:0] C2    = 32'h1b873593;
  localparam logic [WordW-1:0] HAdd  = 32'he6546b64;
  localparam logic [WordW-1:0] HMul  = 32'h00000005;
  localparam logic [WordW-1:0] F1    = 32'h85ebca6b;
  localparam logic [WordW-1:0] F2    = 32'hc2b2ae35;

  localparam logic [BytesW-1:0] FullBytes = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K_C2,
    ST_K_DONE,
    ST_H_ADD,
    ST_FIN_F1,
    ST_FIN_F2,
    ST_FIN_OUT
  } st_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_C1,
    MUL_C2,
    MUL_H5,
    MUL_F1,
    MUL_F2
  } mul_sel_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     h_add;
    logic     h_xor;
    logic     out_load;
  } ctrl_t;

  // byte counts above four count as four
  function automatic logic [BytesW-1:0] clamp_bytes(input logic [BytesW-1:0] nb);
    clamp_bytes = (nb > FullBytes) ? FullBytes : nb;
  endfunction

  // keep only the valid low bytes of a chunk
  function automatic logic [WordW-1:0] mask_chunk(input logic [WordW-1:0] data,
                                                  input logic [BytesW-1:0] nb);
    logic [WordW-1:0] m;
    case (nb)
      3'd0:    m = 32'h00000000;
      3'd1:    m = 32'h000000ff;
      3'd2:    m = 32'h0000ffff;
      3'd3:    m = 32'h00ffffff;
      default: m = 32'hffffffff;
    endcase
    mask_chunk = data & m;
  endfunction

endpackage

>>> design/mm3_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3 channel interfaces
// Valid/ready channels for key chunks, hash results and the seed register.
// ----------------------------------------------------------------------------

// key chunk channel
interface mm3_chunk_if;
  logic                          valid;
  logic                          ready;
  logic [mm3_pkg::WordW-1:0]     chunk_data;
  logic [mm3_pkg::BytesW-1:0]    chunk_bytes;
  logic                          last_chunk;

  modport source (output valid, chunk_data, chunk_bytes, last_chunk, input ready);
  modport sink   (input valid, chunk_data, chunk_bytes, last_chunk, output ready);
endinterface

// hash result channel
interface mm3_hash_if;
  logic                      valid;
  logic                      ready;
  logic [mm3_pkg::WordW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// seed register write channel
interface mm3_seed_if;
  logic                      valid;
  logic                      ready;
  logic [mm3_pkg::WordW-1:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

>>> design/murmur3_32_byte_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_32_byte_hash
// 32-bit murmur3 (x86_32) over a byte key streamed as little-endian chunks.
// ----------------------------------------------------------------------------
//
//   channel  role  payload                                 transfer
//   -------  ----  --------------------------------------  ---------------------
//   chunk    sink  chunk_data[31:0] chunk_bytes[2:0] last  valid & ready
//   hash     src   hash_value[31:0]                        valid & ready
//   cfg      sink  seed[31:0]                              valid & ready (always)
//
// a full chunk steps through ST_IDLE, ST_K_C2, ST_K_DONE and ST_H_ADD, a
// partial one stops after ST_K_DONE and an empty one after ST_IDLE, with the
// dependent products (three for a full chunk, two for a partial one) going
// through the single shared multiplier. a last chunk then adds ST_FIN_F1,
// ST_FIN_F2 and ST_FIN_OUT before the result is registered; chunk.ready is
// high only while the sequencer is idle. a result waits in the output register
// while the next key is taken in; the sequencer holds in its last finalisation
// step only while that register is still full.
// synchronous reset clears the seed to zero and empties the output.
// ----------------------------------------------------------------------------
module murmur3_32_byte_hash (
  input  logic           clk,
  input  logic           rst,
  mm3_chunk_if.sink      chunk,
  mm3_hash_if.source     hash,
  mm3_seed_if.sink       cfg
);

  mm3_pkg::ctrl_t                ctrl;
  logic [mm3_pkg::BytesW-1:0]    nbytes;
  logic [mm3_pkg::WordW-1:0]     seed;
  logic [mm3_pkg::WordW-1:0]     h;
  logic [mm3_pkg::WordW-1:0]     count;
  logic                          in_key;
  logic [mm3_pkg::WordW-1:0]     prod;
  logic [mm3_pkg::WordW-1:0]     mul_a;
  logic [mm3_pkg::WordW-1:0]     mul_b;
  logic [mm3_pkg::WordW-1:0]     hk;
  logic [mm3_pkg::WordW-1:0]     hl;
  logic                          out_valid;
  logic [mm3_pkg::WordW-1:0]     out_data;

  assign nbytes = mm3_pkg::clamp_bytes(chunk.chunk_bytes);

  // seed register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg.valid) begin
      seed <= cfg.seed;
    end
  end

  // sequencer
  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chunk.valid),
    .in_nbytes (nbytes),
    .in_last   (chunk.last_chunk),
    .out_valid (out_valid),
    .out_ready (hash.ready),
    .in_ready  (chunk.ready),
    .ctrl      (ctrl)
  );

  // operand selection for the shared multiplier
  assign hk = h ^ prod;
  assign hl = h ^ count;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      mm3_pkg::MUL_C1: begin
        mul_a = mm3_pkg::mask_chunk(chunk.chunk_data, nbytes);
        mul_b = mm3_pkg::C1;
      end
      mm3_pkg::MUL_C2: begin
        mul_a = {prod[16:0], prod[31:17]};
        mul_b = mm3_pkg::C2;
      end
      mm3_pkg::MUL_H5: begin
        mul_a = {hk[18:0], hk[31:19]};
        mul_b = mm3_pkg::HMul;
      end
      mm3_pkg::MUL_F1: begin
        mul_a = hl ^ (hl >> 16);
        mul_b = mm3_pkg::F1;
      end
      mm3_pkg::MUL_F2: begin
        mul_a = prod ^ (prod >> 13);
        mul_b = mm3_pkg::F2;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  mm3_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // key state: a new key starts from the seed and a zero count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_key <= 1'b0;
      h      <= '0;
      count  <= '0;
    end else begin
      if (ctrl.accept) begin
        in_key <= 1'b1;
        h      <= in_key ? h : seed;
        count  <= (in_key ? count : '0) + {{(mm3_pkg::WordW-mm3_pkg::BytesW){1'b0}}, nbytes};
      end else if (ctrl.h_add) begin
        h <= prod + mm3_pkg::HAdd;
      end else if (ctrl.h_xor) begin
        h <= hk;
      end
      if (ctrl.out_load) begin
        in_key <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data <= prod ^ (prod >> 16);
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_data;

endmodule

>>> design/mm3_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_mul
// Shared 32x32 multiplier keeping the low word, product registered.
// ----------------------------------------------------------------------------
module mm3_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [mm3_pkg::WordW-1:0] a,
  input  logic [mm3_pkg::WordW-1:0] b,
  output logic [mm3_pkg::WordW-1:0] prod
);

  logic [2*mm3_pkg::WordW-1:0] full;

  // full product, low word kept
  assign full = {{mm3_pkg::WordW{1'b0}}, a} * {{mm3_pkg::WordW{1'b0}}, b};

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[mm3_pkg::WordW-1:0];
    end
  end

endmodule

>>> design/mm3_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer that steps one chunk through the shared multiplier.
// ----------------------------------------------------------------------------
module mm3_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [mm3_pkg::BytesW-1:0] in_nbytes,
  input  logic                       in_last,
  input  logic                       out_valid,
  input  logic                       out_ready,
  output logic                       in_ready,
  output mm3_pkg::ctrl_t             ctrl
);

  mm3_pkg::st_t state;
  mm3_pkg::st_t state_next;
  logic         full;
  logic         last;
  logic         out_free;

  assign out_free = !out_valid || out_ready;

  // state and chunk flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm3_pkg::ST_IDLE;
      full  <= 1'b0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mm3_pkg::ST_IDLE && in_valid) begin
        full <= (in_nbytes == mm3_pkg::FullBytes);
        last <= in_last;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mm3_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_nbytes != '0) begin
            state_next = mm3_pkg::ST_K_C2;
          end else if (in_last) begin
            state_next = mm3_pkg::ST_FIN_F1;
          end
        end
      end
      mm3_pkg::ST_K_C2: begin
        state_next = mm3_pkg::ST_K_DONE;
      end
      mm3_pkg::ST_K_DONE: begin
        if (full) begin
          state_next = mm3_pkg::ST_H_ADD;
        end else begin
          state_next = last ? mm3_pkg::ST_FIN_F1 : mm3_pkg::ST_IDLE;
        end
      end
      mm3_pkg::ST_H_ADD: begin
        state_next = last ? mm3_pkg::ST_FIN_F1 : mm3_pkg::ST_IDLE;
      end
      mm3_pkg::ST_FIN_F1: begin
        state_next = mm3_pkg::ST_FIN_F2;
      end
      mm3_pkg::ST_FIN_F2: begin
        state_next = mm3_pkg::ST_FIN_OUT;
      end
      mm3_pkg::ST_FIN_OUT: begin
        if (out_free) begin
          state_next = mm3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mm3_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    ctrl.accept   = 1'b0;
    ctrl.mul_en   = 1'b0;
    ctrl.mul_sel  = mm3_pkg::MUL_C1;
    ctrl.h_add    = 1'b0;
    ctrl.h_xor    = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      mm3_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
        ctrl.mul_en = in_valid;
      end
      mm3_pkg::ST_K_C2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = mm3_pkg::MUL_C2;
      end
      mm3_pkg::ST_K_DONE: begin
        ctrl.mul_en  = full;
        ctrl.mul_sel = mm3_pkg::MUL_H5;
        ctrl.h_xor   = !full;
      end
      mm3_pkg::ST_H_ADD: begin
        ctrl.h_add = 1'b1;
      end
      mm3_pkg::ST_FIN_F1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = mm3_pkg::MUL_F1;
      end
      mm3_pkg::ST_FIN_F2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = mm3_pkg::MUL_F2;
      end
      mm3_pkg::ST_FIN_OUT: begin
        ctrl.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> design/mm3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_checker
// Port-level checks on the murmur3 hash block, bound to the top level.
// ----------------------------------------------------------------------------
module mm3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       chunk_valid,
  input logic                       chunk_ready,
  input logic [mm3_pkg::BytesW-1:0] chunk_bytes,
  input logic                       hash_valid,
  input logic                       hash_ready,
  input logic [mm3_pkg::WordW-1:0]  hash_value
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !hash_valid)
    else $error("hash valid after reset");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && !hash_ready |=> hash_valid && $stable(hash_value))
    else $error("stalled hash result changed");

  // a chunk with bytes keeps the sequencer busy through ST_K_C2 and ST_K_DONE
  a_busy: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && chunk_ready && chunk_bytes != '0 |=> !chunk_ready ##1 !chunk_ready)
    else $error("chunk taken while multiplier busy");

  // a new result appears only as the sequencer goes back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> chunk_ready)
    else $error("result raised while sequencer busy");

endmodule

bind murmur3_32_byte_hash mm3_checker u_mm3_checker (
  .clk         (clk),
  .rst         (rst),
  .chunk_valid (chunk.valid),
  .chunk_ready (chunk.ready),
  .chunk_bytes (chunk.chunk_bytes),
  .hash_valid  (hash.valid),
  .hash_ready  (hash.ready),
  .hash_value  (hash.hash_value)
);

>>> test/tb_murmur3_32_byte_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur3_32_byte_hash
// Self-checking bench for the streamed murmur3 x86_32 byte hash. A directed
// table covers empty keys, byte-count extremes, masked tails, short and empty
// chunks inside a key and seed writes (including one in the middle of a key).
// Random keys follow under several seeds. Each result is checked against a
// local model of the hash or a value typed into the table, with random idling on
// both channels and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_murmur3_32_byte_hash;

  typedef logic [mm3_pkg::WordW-1:0]  word_t;
  typedef logic [mm3_pkg::BytesW-1:0] nbytes_t;

  // published mixing constants of the x86_32 variant
  localparam word_t MixC1   = 32'hcc9e2d51;
  localparam word_t MixC2   = 32'h1b873593;
  localparam word_t MixAdd  = 32'he6546b64;
  localparam word_t MixMul  = 32'h00000005;
  localparam word_t FinMul1 = 32'h85ebca6b;
  localparam word_t FinMul2 = 32'hc2b2ae35;

  localparam nbytes_t FullChunk = 3'd4;

  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 10;
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 400;
  localparam int RandomItems  = 1300;
  localparam int NumPhases    = 6;
  localparam int CycleLimit   = 400000;

  typedef enum logic [1:0] {
    ROW_CHUNK,
    ROW_SEED
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    word_t     data;
    nbytes_t   nbytes;
    logic      last;
    logic      typed;
    word_t     want;
  } stim_row_t;

  localparam int NumRows = 25;

  // directed table: a seed row carries the seed value in the data column
  stim_row_t directed_rows [0:NumRows-1] = '{
    // empty key straight after reset hashes to zero
    '{ROW_CHUNK, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
    // empty key, bytes above the count ignored
    '{ROW_CHUNK, 32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h00000000},
    '{ROW_CHUNK, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h87654321, 3'd4, 1'b0, 1'b0, 32'h0},
    // three-byte tail with a dirty top byte
    '{ROW_CHUNK, 32'hffabcdef, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'hffffff61, 3'd1, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'hffff6261, 3'd2, 1'b1, 1'b0, 32'h0},
    // oversized byte counts behave as full chunks
    '{ROW_CHUNK, 32'h12345678, 3'd5, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h9abcdef0, 3'd6, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h0fedcba9, 3'd7, 1'b1, 1'b0, 32'h0},
    // short chunk ahead of the last one
    '{ROW_CHUNK, 32'h5555beef, 3'd2, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'hdeadbeef, 3'd4, 1'b1, 1'b0, 32'h0},
    // empty chunk inside a key
    '{ROW_CHUNK, 32'h11111111, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'haaaaaa33, 3'd1, 1'b1, 1'b0, 32'h0},
    // seed extremes on empty keys
    '{ROW_SEED,  32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    '{ROW_SEED,  32'h00000001, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    // seed changed while a key is open: applies from the next key
    '{ROW_CHUNK, 32'h6c6c6548, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_SEED,  32'h9747b28c, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h0000216f, 3'd2, 1'b1, 1'b0, 32'h0},
    '{ROW_CHUNK, 32'h00636261, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_SEED,  32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0}
  };

  logic clk;
  logic rst;

  mm3_chunk_if chunk_ch ();
  mm3_hash_if  hash_ch ();
  mm3_seed_if  seed_ch ();

  murmur3_32_byte_hash dut (
    .clk   (clk),
    .rst   (rst),
    .chunk (chunk_ch),
    .hash  (hash_ch),
    .cfg   (seed_ch)
  );

  // hash model state
  word_t seed_now;
  word_t run_hash;
  word_t key_len;
  bit    key_open;

  word_t pending_hashes [$];

  int  errors;
  int  chunk_count;
  int  key_count;
  int  hashes_checked;
  int  seed_writes;
  int  holds_done;
  int  cycles;
  bit  calm;
  bit  hold_req;

  // clock
  initial clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  // k1 mix
  function automatic word_t mix_key(input word_t k);
    word_t x;
    x = k * MixC1;
    x = {x[16:0], x[31:17]};
    return x * MixC2;
  endfunction

  // h1 mix
  function automatic word_t mix_hash(input word_t h, input word_t k);
    word_t x;
    x = h ^ k;
    x = {x[18:0], x[31:19]};
    return x * MixMul + MixAdd;
  endfunction

  // length fold and avalanche
  function automatic word_t finalise(input word_t h, input word_t len);
    word_t x;
    x = h ^ len;
    x = x ^ (x >> 16);
    x = x * FinMul1;
    x = x ^ (x >> 13);
    x = x * FinMul2;
    x = x ^ (x >> 16);
    return x;
  endfunction

  // fold one chunk into the running hash, returns 1 when a hash comes out
  function automatic bit absorb_chunk(input word_t d, input nbytes_t nb_raw,
                                      input logic last, output word_t digest);
    nbytes_t nb;
    word_t   h;
    word_t   keep;
    digest = '0;
    nb = (nb_raw > FullChunk) ? FullChunk : nb_raw;
    if (!key_open) begin
      run_hash = seed_now;
      key_len  = '0;
      key_open = 1'b1;
    end
    h = run_hash;
    if (nb == FullChunk) begin
      h = mix_hash(h, mix_key(d));
    end else if (nb != 3'd0) begin
      keep = 32'hffffffff >> (32 - 8 * int'(nb));
      h = h ^ mix_key(d & keep);
    end
    key_len  = key_len + word_t'(nb);
    run_hash = h;
    if (!last) return 1'b0;
    digest   = finalise(h, key_len);
    run_hash = seed_now;
    key_len  = '0;
    key_open = 1'b0;
    return 1'b1;
  endfunction

  // random word with the occasional extreme
  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one chunk and hold it until the transfer
  task automatic send_chunk(input word_t d, input nbytes_t nb, input logic last,
                            input logic typed, input word_t want);
    word_t digest;
    chunk_ch.valid       <= 1'b1;
    chunk_ch.chunk_data  <= d;
    chunk_ch.chunk_bytes <= nb;
    chunk_ch.last_chunk  <= last;
    do @(posedge clk); while (!(chunk_ch.valid && chunk_ch.ready));
    chunk_count++;
    if (absorb_chunk(d, nb, last, digest)) begin
      pending_hashes.push_back(typed ? want : digest);
      key_count++;
    end
  endtask

  // random sender gap with junk on the payload
  task automatic idle_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      chunk_ch.valid       <= 1'b0;
      chunk_ch.chunk_data  <= $urandom;
      chunk_ch.chunk_bytes <= nbytes_t'($urandom_range(0, 7));
      chunk_ch.last_chunk  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // seed write once the block has gone quiet
  task automatic write_seed(input word_t v);
    chunk_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= v;
    do @(posedge clk); while (!(seed_ch.valid && seed_ch.ready));
    seed_ch.valid <= 1'b0;
    seed_now = v;
    if (!key_open) run_hash = v;
    seed_writes++;
  endtask

  // one random key: mostly well formed, sometimes broken
  task automatic send_key();
    int      n;
    nbytes_t nb;
    logic    last;
    if ($urandom_range(0, 9) < 8) begin
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        send_chunk(rand_word(), FullChunk, 1'b0, 1'b0, '0);
        idle_gap();
      end
      send_chunk(rand_word(), nbytes_t'($urandom_range(0, 4)), 1'b1, 1'b0, '0);
      idle_gap();
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        nb   = nbytes_t'($urandom_range(0, 7));
        last = (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1));
        send_chunk(rand_word(), nb, last, 1'b0, '0);
        idle_gap();
      end
    end
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin
    hash_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hash_ch.ready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hash_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        hash_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && hash_ch.valid && hash_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %h", $time, hash_ch.hash_value);
        errors++;
      end else begin
        if (hash_ch.hash_value !== pending_hashes[0]) begin
          $display("%0t: hash mismatch, expected %h, got %h",
                   $time, pending_hashes[0], hash_ch.hash_value);
          errors++;
        end
        void'(pending_hashes.pop_front());
        hashes_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out with %0d hashes outstanding", $time, pending_hashes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    int    target;
    word_t phase_seed;
    rst                  <= 1'b1;
    chunk_ch.valid       <= 1'b0;
    chunk_ch.chunk_data  <= '0;
    chunk_ch.chunk_bytes <= '0;
    chunk_ch.last_chunk  <= 1'b0;
    seed_ch.valid        <= 1'b0;
    seed_ch.seed         <= '0;
    errors         = 0;
    chunk_count    = 0;
    key_count      = 0;
    hashes_checked = 0;
    seed_writes    = 0;
    holds_done     = 0;
    cycles         = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    seed_now       = '0;
    run_hash       = '0;
    key_len        = '0;
    key_open       = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NumRows; r++) begin
      if (directed_rows[r].kind == ROW_SEED) begin
        write_seed(directed_rows[r].data);
      end else begin
        send_chunk(directed_rows[r].data, directed_rows[r].nbytes, directed_rows[r].last,
                   directed_rows[r].typed, directed_rows[r].want);
        idle_gap();
      end
    end

    // random keys, a new seed per phase, no idling in the last phase
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       phase_seed = 32'h00000000;
        1:       phase_seed = 32'hffffffff;
        3:       phase_seed = 32'h80000000;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      if (p == 2) hold_req = 1'b1;
      if (p == NumPhases - 1) calm = 1'b1;
      target = chunk_count + RandomItems / NumPhases;
      while (chunk_count < target) send_key();
    end

    // drain
    chunk_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("run covered %0d chunks in %0d keys, %0d hashes compared",
             chunk_count, key_count, hashes_checked);
    $display("seed writes %0d, long output hold-offs %0d, mismatches %0d",
             seed_writes, holds_done, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
